// ----- hdl/eomd_pkg.sv -----
// Executed-order message decoder: shared constants, types and helpers.
// Used by every eomd module and the testbench; no dependencies.
package eomd_pkg;

  // Width of the id window; the record carries at most ID_OUT_CHARS of it.
  localparam int ID_CHARS     = 14;
  localparam int ID_OUT_CHARS = (ID_CHARS < 14) ? ID_CHARS : 14;
  localparam int ID_CNT_W     = $clog2(ID_CHARS + 1);
  localparam int ID_IDX_W     = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;

  localparam int OFS_W = 6;
  localparam logic [OFS_W-1:0] OFS_ID_START = 6'd9;
  localparam logic [OFS_W-1:0] OFS_ID_LEN   = OFS_W'(ID_CHARS);
  localparam logic [OFS_W-1:0] OFS_VOLUME   = 6'd23;
  localparam logic [OFS_W-1:0] OFS_PRICE    = 6'd27;
  localparam logic [OFS_W-1:0] OFS_MATCH    = 6'd32;
  localparam logic [OFS_W-1:0] OFS_CPART    = 6'd36;
  localparam logic [OFS_W-1:0] OFS_FLAGS    = 6'd43;
  localparam logic [OFS_W-1:0] WORD_LEN     = 6'd4;
  localparam logic [OFS_W-1:0] OFS_ZERO     = 6'd0;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Flag byte layout.
  localparam int FLAG_OWN_TRADE = 7;
  localparam int FLAG_INTERNAL  = 5;
  localparam int FLAG_LIQ_HI    = 4;
  localparam int FLAG_LIQ_LO    = 3;

  localparam logic [1:0] LIQ_ADDED   = 2'd0;
  localparam logic [1:0] LIQ_REMOVED = 2'd1;
  localparam logic [1:0] LIQ_NONE    = 2'd2;

  // One byte step handed from the offset tracker to the field collectors.
  typedef struct packed {
    logic             active;   // byte belongs to a message
    logic             restart;  // first byte: clear collected fields
    logic [OFS_W-1:0] ofs;      // offset of this byte
    logic [7:0]       data;
  } step_t;

  typedef struct packed {
    logic [31:0] exec_volume;
    logic [31:0] price_raw;
    logic [31:0] match_id;
    logic [31:0] counterpart;
    logic [63:0] id_low;
    logic [47:0] id_high;
    logic [3:0]  id_length;
    logic        own_trade;
    logic        internalized;
    logic [1:0]  liquidity;
  } result_t;

  function automatic logic in_field(logic [OFS_W-1:0] ofs, logic [OFS_W-1:0] start,
                                    logic [OFS_W-1:0] len);
    return (ofs >= start) && (ofs < start + len);
  endfunction

endpackage

// ----- hdl/eomd_msg_if.sv -----
// Message byte channel: valid/ready handshake with one raw byte per transaction.
// Standalone; no package dependency.
interface eomd_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// ----- hdl/eomd_rec_if.sv -----
// Decoded record channel: valid/ready handshake with one record per transaction.
// Standalone; no package dependency.
interface eomd_rec_if;
  logic        valid;
  logic        ready;
  logic [31:0] exec_volume;
  logic [31:0] price_raw;
  logic [31:0] match_id;
  logic [31:0] counterpart;
  logic [63:0] id_low;
  logic [47:0] id_high;
  logic [3:0]  id_length;
  logic        own_trade;
  logic        internalized;
  logic [1:0]  liquidity;

  modport source (output valid, output exec_volume, output price_raw,
                  output match_id, output counterpart, output id_low,
                  output id_high, output id_length, output own_trade,
                  output internalized, output liquidity, input ready);
  modport sink (input valid, input exec_volume, input price_raw,
                input match_id, input counterpart, input id_low,
                input id_high, input id_length, input own_trade,
                input internalized, input liquidity, output ready);
endinterface

// ----- hdl/eomd_field_acc.sv -----
// Numeric field collectors: volume, price, match number and counterpart bytes.
// Depends on eomd_pkg (step_t, offsets, in_field).
module eomd_field_acc (
  input  logic              clk,
  input  logic              rst,
  input  eomd_pkg::step_t   step,
  output logic [31:0]       volume,
  output logic [31:0]       price,
  output logic [31:0]       match_no,
  output logic [31:0]       cpart
);

  logic [1:0] lane;

  assign lane = 2'(step.ofs - eomd_pkg::OFS_CPART);

  always_ff @(posedge clk) begin
    if (rst || step.restart) begin
      volume   <= '0;
      price    <= '0;
      match_no <= '0;
      cpart    <= '0;
    end else if (step.active) begin
      // big-endian words shift in from the right
      if (eomd_pkg::in_field(step.ofs, eomd_pkg::OFS_VOLUME, eomd_pkg::WORD_LEN)) begin
        volume <= {volume[23:0], step.data};
      end
      if (eomd_pkg::in_field(step.ofs, eomd_pkg::OFS_PRICE, eomd_pkg::WORD_LEN)) begin
        price <= {price[23:0], step.data};
      end
      if (eomd_pkg::in_field(step.ofs, eomd_pkg::OFS_MATCH, eomd_pkg::WORD_LEN)) begin
        match_no <= {match_no[23:0], step.data};
      end
      // counterpart fills byte lanes, first byte lowest
      if (eomd_pkg::in_field(step.ofs, eomd_pkg::OFS_CPART, eomd_pkg::WORD_LEN)) begin
        cpart[{lane, 3'b000} +: 8] <= cpart[{lane, 3'b000} +: 8] | step.data;
      end
    end
  end

endmodule

// ----- hdl/eomd_id_collect.sv -----
// Order id collector: keeps the non-space characters of the id window in order.
// Depends on eomd_pkg (step_t, id window constants, in_field).
module eomd_id_collect (
  input  logic                            clk,
  input  logic                            rst,
  input  eomd_pkg::step_t                 step,
  output logic [63:0]                     id_low,
  output logic [47:0]                     id_high,
  output logic [eomd_pkg::ID_CNT_W-1:0]   id_count
);

  logic [7:0]   id_chars [eomd_pkg::ID_CHARS];
  logic         keep;
  logic [111:0] id_flat;

  assign keep = step.active && !step.restart && (step.data != eomd_pkg::SPACE_CHAR)
             && eomd_pkg::in_field(step.ofs, eomd_pkg::OFS_ID_START, eomd_pkg::OFS_ID_LEN);

  // Character slots carry no reset: slots at or past the count are masked.
  always_ff @(posedge clk) begin
    if (keep && (id_count < eomd_pkg::ID_CNT_W'(eomd_pkg::ID_CHARS))) begin
      id_chars[id_count[eomd_pkg::ID_IDX_W-1:0]] <= step.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || step.restart) begin
      id_count <= '0;
    end else if (keep) begin
      id_count <= id_count + 1'b1;
    end
  end

  always_comb begin
    id_flat = '0;
    for (int k = 0; k < eomd_pkg::ID_OUT_CHARS; k++) begin
      if (eomd_pkg::ID_CNT_W'(k) < id_count) begin
        id_flat[8*k +: 8] = id_chars[k];
      end
    end
  end

  assign id_low  = id_flat[63:0];
  assign id_high = id_flat[111:64];

endmodule

// ----- hdl/eomd_out_reg.sv -----
// Record output register: holds one decoded record until the receiver takes it.
// Depends on eomd_pkg (result_t) and eomd_rec_if.
module eomd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  eomd_pkg::result_t result,
  eomd_rec_if.source        rec
);

  eomd_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else if (load) begin
      rec.valid <= 1'b1;
    end else if (rec.ready) begin
      rec.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign rec.exec_volume   = held.exec_volume;
  assign rec.price_raw     = held.price_raw;
  assign rec.match_id      = held.match_id;
  assign rec.counterpart   = held.counterpart;
  assign rec.id_low        = held.id_low;
  assign rec.id_high       = held.id_high;
  assign rec.id_length     = held.id_length;
  assign rec.own_trade     = held.own_trade;
  assign rec.internalized  = held.internalized;
  assign rec.liquidity     = held.liquidity;

endmodule

// ----- hdl/executed_order_message_decoder.sv -----
// Executed-order message decoder, top level.
// Depends on eomd_pkg, eomd_msg_if, eomd_rec_if, eomd_field_acc, eomd_id_collect,
// eomd_out_reg.
//
// Usage:
//   msg carries one message byte per transaction; first_byte marks offset zero
//   and always restarts decoding, even in the middle of a message. Bytes seen
//   outside a message, and bytes after the flag byte, are dropped.
//   rec carries one decoded record per message that reaches its flag byte at
//   offset 43: volume, raw price (four implied decimals), match number,
//   counterpart bytes, the id with spaces removed, and the flag bits.
// Latency and throughput:
//   One byte per cycle while msg.ready is high. The record is valid the cycle
//   after the flag byte transaction. Each byte passes through the offset compares
//   into the field registers; the record register is the only output stage.
// Reset (rst, synchronous): clears the offset, the in-message flag, the id
//   count, the numeric fields and the record valid.
// Stall: while a record waits in the output register and rec.ready is low,
//   msg.ready drops; it stays high whenever the register is empty or drains.
module executed_order_message_decoder (
  input  logic       clk,
  input  logic       rst,
  eomd_msg_if.sink   msg,
  eomd_rec_if.source rec
);

  logic [eomd_pkg::OFS_W-1:0]    byte_offset;
  logic [eomd_pkg::OFS_W-1:0]    byte_offset_next;
  logic                          in_message;
  logic                          in_message_next;
  logic                          accept;
  logic                          emit;
  eomd_pkg::step_t               step;
  eomd_pkg::result_t             result;
  logic [31:0]                   volume;
  logic [31:0]                   price;
  logic [31:0]                   match_no;
  logic [31:0]                   cpart;
  logic [63:0]                   id_low;
  logic [47:0]                   id_high;
  logic [eomd_pkg::ID_CNT_W-1:0] id_count;

  // Take a byte whenever the record register is empty or being emptied.
  assign msg.ready = !rec.valid || rec.ready;
  assign accept    = msg.valid && msg.ready;

  // A first byte starts at offset zero regardless of the tracked offset.
  always_comb begin
    step.restart = accept && msg.first_byte;
    step.active  = accept && (msg.first_byte || in_message);
    step.ofs     = msg.first_byte ? eomd_pkg::OFS_ZERO : byte_offset;
    step.data    = msg.data_byte;
  end

  assign emit = step.active && (step.ofs == eomd_pkg::OFS_FLAGS);

  // Advance the offset on every message byte; drop out of the message after
  // the flag byte.
  always_comb begin
    byte_offset_next = byte_offset;
    in_message_next  = in_message;
    if (step.active) begin
      byte_offset_next = step.ofs + 1'b1;
      in_message_next  = !emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      in_message  <= 1'b0;
    end else begin
      byte_offset <= byte_offset_next;
      in_message  <= in_message_next;
    end
  end

  eomd_field_acc u_field_acc (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .volume   (volume),
    .price    (price),
    .match_no (match_no),
    .cpart    (cpart)
  );

  eomd_id_collect u_id_collect (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .id_low   (id_low),
    .id_high  (id_high),
    .id_count (id_count)
  );

  // Assemble the record; no field changes at the flag offset, so the held
  // values are already final when the flag byte arrives.
  always_comb begin
    result.exec_volume   = volume;
    result.price_raw     = price;
    result.match_id      = match_no;
    result.counterpart   = cpart;
    result.id_low        = id_low;
    result.id_high       = id_high;
    result.id_length     = 4'(id_count);
    result.own_trade     = msg.data_byte[eomd_pkg::FLAG_OWN_TRADE];
    result.internalized  = msg.data_byte[eomd_pkg::FLAG_INTERNAL];
    case (msg.data_byte[eomd_pkg::FLAG_LIQ_HI:eomd_pkg::FLAG_LIQ_LO])
      eomd_pkg::LIQ_ADDED:   result.liquidity = eomd_pkg::LIQ_ADDED;
      eomd_pkg::LIQ_REMOVED: result.liquidity = eomd_pkg::LIQ_REMOVED;
      default:               result.liquidity = eomd_pkg::LIQ_NONE;
    endcase
  end

  eomd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (emit),
    .result (result),
    .rec    (rec)
  );

`ifndef SYNTH
  a_emit_shows_record: assert property (@(posedge clk) disable iff (rst)
    emit |=> rec.valid)
    else $error("record not presented after flag byte");

  a_emit_ends_message: assert property (@(posedge clk) disable iff (rst)
    emit |=> !in_message)
    else $error("message still open after flag byte");

  a_offset_bounded: assert property (@(posedge clk) disable iff (rst)
    in_message |-> (byte_offset <= eomd_pkg::OFS_FLAGS))
    else $error("offset ran past flag byte inside a message");

  a_id_count_bounded: assert property (@(posedge clk) disable iff (rst)
    id_count <= eomd_pkg::ID_CNT_W'(eomd_pkg::ID_CHARS))
    else $error("id count exceeds id window");

  a_record_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rec.valid) |-> $past(emit))
    else $error("record appeared without a flag byte");
`endif

endmodule

// ----- tb/eomd_record_checker.sv -----
// Record checker for the executed-order message decoder: watches both channels,
// predicts each decoded record and compares it field by field.
// Depends on eomd_pkg, eomd_msg_if and eomd_rec_if.
module eomd_record_checker (
  input  logic clk,
  input  logic rst,
  eomd_msg_if  msg,
  eomd_rec_if  rec,
  output int   fails,
  output int   pending
);

  localparam int ID_WIN = (eomd_pkg::ID_CHARS > 16) ? 16 : eomd_pkg::ID_CHARS;

  logic [eomd_pkg::OFS_W-1:0] next_ofs;
  logic                       in_msg;
  logic [7:0]                 id_slot [16];
  int                         id_kept;
  logic [31:0]                volume_acc;
  logic [31:0]                price_acc;
  logic [31:0]                match_acc;
  logic [31:0]                cpart_acc;
  eomd_pkg::result_t          expected_records [$];
  int                         mismatches = 0;

  function automatic logic hits(int ofs, int start, int len);
    return (ofs >= start) && (ofs < start + len);
  endfunction

  task automatic clear_fields();
    foreach (id_slot[k]) id_slot[k] = '0;
    id_kept    = 0;
    volume_acc = '0;
    price_acc  = '0;
    match_acc  = '0;
    cpart_acc  = '0;
  endtask

  // Advance the decoder state by one accepted byte; queue a record on the flag byte.
  task automatic decode_byte(input logic [7:0] d, input logic f);
    eomd_pkg::result_t r;
    int                ofs;
    int                wlen;
    logic [1:0]        liq_bits;
    if (f) begin
      clear_fields();
      next_ofs = '0;
      in_msg   = 1'b1;
    end else if (!in_msg) begin
      return;
    end
    ofs      = int'(next_ofs);
    wlen     = int'(eomd_pkg::WORD_LEN);
    next_ofs = next_ofs + 1'b1;

    if (hits(ofs, int'(eomd_pkg::OFS_ID_START), ID_WIN) && d != eomd_pkg::SPACE_CHAR) begin
      if (id_kept < ID_WIN) id_slot[id_kept] = d;
      id_kept++;
    end
    if (hits(ofs, int'(eomd_pkg::OFS_VOLUME), wlen)) volume_acc = {volume_acc[23:0], d};
    if (hits(ofs, int'(eomd_pkg::OFS_PRICE), wlen))  price_acc  = {price_acc[23:0], d};
    if (hits(ofs, int'(eomd_pkg::OFS_MATCH), wlen))  match_acc  = {match_acc[23:0], d};
    if (hits(ofs, int'(eomd_pkg::OFS_CPART), wlen))
      cpart_acc[8*(ofs - int'(eomd_pkg::OFS_CPART)) +: 8] = d;
    if (ofs != int'(eomd_pkg::OFS_FLAGS)) return;

    in_msg = 1'b0;
    r = '0;
    for (int k = 0; k < 8; k++)
      if (k < id_kept) r.id_low[8*k +: 8] = id_slot[k];
    for (int k = 8; k < 14; k++)
      if (k < id_kept && k < 16) r.id_high[8*(k-8) +: 8] = id_slot[k];
    r.exec_volume   = volume_acc;
    r.price_raw     = price_acc;
    r.match_id      = match_acc;
    r.counterpart   = cpart_acc;
    r.id_length     = 4'(id_kept);
    r.own_trade     = d[eomd_pkg::FLAG_OWN_TRADE];
    r.internalized  = d[eomd_pkg::FLAG_INTERNAL];
    liq_bits        = d[eomd_pkg::FLAG_LIQ_HI:eomd_pkg::FLAG_LIQ_LO];
    case (liq_bits)
      eomd_pkg::LIQ_ADDED:   r.liquidity = eomd_pkg::LIQ_ADDED;
      eomd_pkg::LIQ_REMOVED: r.liquidity = eomd_pkg::LIQ_REMOVED;
      default:               r.liquidity = eomd_pkg::LIQ_NONE;
    endcase
    expected_records.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    eomd_pkg::result_t want;
    if (rst) begin
      next_ofs = '0;
      in_msg   = 1'b0;
      clear_fields();
      expected_records.delete();
    end else begin
      // The record of a flag byte is registered before it shows up, so pop before push.
      if (rec.valid && rec.ready) begin
        if (expected_records.size() == 0) begin
          $error("record accepted with no record expected");
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          check_field("exec_volume", 64'(want.exec_volume), 64'(rec.exec_volume));
          check_field("price_raw", 64'(want.price_raw), 64'(rec.price_raw));
          check_field("match_id", 64'(want.match_id), 64'(rec.match_id));
          check_field("counterpart", 64'(want.counterpart), 64'(rec.counterpart));
          check_field("id_low", want.id_low, rec.id_low);
          check_field("id_high", 64'(want.id_high), 64'(rec.id_high));
          check_field("id_length", 64'(want.id_length), 64'(rec.id_length));
          check_field("own_trade", 64'(want.own_trade), 64'(rec.own_trade));
          check_field("internalized", 64'(want.internalized), 64'(rec.internalized));
          check_field("liquidity", 64'(want.liquidity), 64'(rec.liquidity));
        end
      end
      if (msg.valid && msg.ready) decode_byte(msg.data_byte, msg.first_byte);
    end
    fails   <= mismatches;
    pending <= expected_records.size();
  end

endmodule

// ----- tb/tb_executed_order_message_decoder.sv -----
// Testbench top for the executed-order message decoder: clock, reset, byte stimulus,
// record back-pressure and the verdict. Depends on eomd_pkg, both channel
// interfaces, executed_order_message_decoder and eomd_record_checker.
module tb_executed_order_message_decoder;

  // bytes up to and including the flag byte
  localparam int FRAME_LEN    = int'(eomd_pkg::OFS_FLAGS) + 1;
  localparam int ID_FIRST     = int'(eomd_pkg::OFS_ID_START);
  localparam int MSG_BYTES    = 1750;           // input bytes over the whole run
  localparam int HOLD_CYCLES  = 400;            // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [7:0] FLAG_CASES [6] = '{8'h08, 8'h10, 8'h18, 8'h80, 8'h20, 8'h67};

  logic clk;
  logic rst;
  logic quiet;       // no idling on either side while set
  int   hold_asks;   // bump to ask the receiver for one long hold-off
  int   msg_bytes;   // input bytes sent so far
  int   chk_fails;
  int   chk_pending;
  logic [7:0] frame [FRAME_LEN];

  eomd_msg_if msg_ch ();
  eomd_rec_if rec_ch ();

  executed_order_message_decoder i_dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .rec (rec_ch)
  );

  eomd_record_checker i_chk (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg_ch),
    .rec     (rec_ch),
    .fails   (chk_fails),
    .pending (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: a hung handshake or a record that never comes ends up here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Record receiver: random back-pressure, none while quiet, and a long
  // hold-off whenever the stimulus asks for one. The hold is counted here so the
  // sender keeps offering bytes and the decoder has to stall its input.
  initial begin
    int hold_seen;
    hold_seen = 0;
    rec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        rec_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        rec_ch.ready <= quiet || ($urandom_range(99) >= 30);
      end
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold it until the
  // transaction completes. Ready is sampled at the falling edge, where it is
  // settled for the coming rising edge. Call and return at a rising edge.
  task automatic send_byte(input logic [7:0] d, input logic f);
    logic taken;
    if (!quiet)
      while ($urandom_range(99) < 30) begin
        msg_ch.valid <= 1'b0;
        @(posedge clk);
      end
    msg_ch.valid      <= 1'b1;
    msg_ch.data_byte  <= d;
    msg_ch.first_byte <= f;
    do begin
      @(negedge clk);
      taken = msg_ch.ready;
      @(posedge clk);
    end while (!taken);
    msg_bytes++;
  endtask

  // Send the first len bytes of the frame, the first one marked as a message start.
  task automatic send_frame(input int len);
    for (int k = 0; k < len; k++) begin
      send_byte(frame[k], k == 0);
    end
  endtask

  // Stray bytes; first_pct percent of them start a message of their own.
  task automatic send_noise(input int n, input int first_pct);
    repeat (n) send_byte(8'($urandom), $urandom_range(99) < first_pct);
  endtask

  // Random frame; each id position is a space with probability space_pct percent.
  task automatic fill_frame(input int space_pct);
    foreach (frame[k]) frame[k] = 8'($urandom);
    for (int k = ID_FIRST; k < ID_FIRST + eomd_pkg::ID_CHARS; k++)
      if ($urandom_range(99) < space_pct) frame[k] = eomd_pkg::SPACE_CHAR;
  endtask

  // Drop valid and wait until every expected record has been taken.
  task automatic wait_drained();
    msg_ch.valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int msg_no;
    int pick;
    rst               <= 1'b1;
    quiet             <= 1'b0;
    hold_asks         <= 0;
    msg_bytes          = 0;
    msg_ch.valid      <= 1'b0;
    msg_ch.data_byte  <= '0;
    msg_ch.first_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    // Bytes before any message: drop them, no record.
    send_noise(2, 0);

    // All-zero fields, id entirely spaces: empty id, liquidity added.
    foreach (frame[k]) frame[k] = 8'h00;
    for (int k = ID_FIRST; k < ID_FIRST + eomd_pkg::ID_CHARS; k++)
      frame[k] = eomd_pkg::SPACE_CHAR;
    send_frame(FRAME_LEN);
    send_noise(2, 0);  // trailing bytes after the flag byte are ignored

    // All ones: full id, every numeric field at its maximum, liquidity none.
    foreach (frame[k]) frame[k] = 8'hFF;
    send_frame(FRAME_LEN);

    // Each liquidity code and each flag bit on its own.
    foreach (FLAG_CASES[i]) begin
      fill_frame(40);
      frame[eomd_pkg::OFS_FLAGS] = FLAG_CASES[i];
      send_frame(FRAME_LEN);
    end

    // Leading and trailing spaces around a compacted id.
    fill_frame(0);
    for (int k = 0; k < 3; k++) begin
      frame[ID_FIRST + k]                          = eomd_pkg::SPACE_CHAR;
      frame[ID_FIRST + eomd_pkg::ID_CHARS - 1 - k] = eomd_pkg::SPACE_CHAR;
    end
    send_frame(FRAME_LEN);

    // New message mid-message: abandon inside the id window, then again just before
    // the flag byte.
    fill_frame(30);
    send_frame(20);
    fill_frame(30);
    send_frame(FRAME_LEN - 1);
    fill_frame(30);
    send_frame(FRAME_LEN);

    // Two message starts back to back.
    send_byte(8'h33, 1'b1);
    fill_frame(30);
    send_frame(FRAME_LEN);

    // Random part: mostly complete messages with random content, some cut
    // short by a new start, some stray noise.
    msg_no = 0;
    while (msg_bytes < MSG_BYTES) begin
      msg_no++;
      quiet <= (msg_no >= 22 && msg_no < 30);
      if (msg_no == 10) hold_asks <= hold_asks + 1;
      if (msg_no == 20) wait_drained();
      pick = $urandom_range(99);
      fill_frame(($urandom_range(9) == 0) ? 100 : $urandom_range(60));
      if (pick < 80) begin
        send_frame(FRAME_LEN);
        send_noise($urandom_range(3), 0);
      end else if (pick < 90) begin
        send_frame($urandom_range(FRAME_LEN - 1, 1));
      end else begin
        send_noise($urandom_range(6, 1), 10);
      end
    end

    // Hold until every record is in, then let the output stage settle.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk_fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/eomd_pkg.sv
hdl/eomd_msg_if.sv
hdl/eomd_rec_if.sv
hdl/eomd_field_acc.sv
hdl/eomd_id_collect.sv
hdl/eomd_out_reg.sv
hdl/executed_order_message_decoder.sv
tb/eomd_record_checker.sv
tb/tb_executed_order_message_decoder.sv
